@@ src/csb_pkg.sv @@
// ----------------------------------------------------------------------------
// csb_pkg
// Shared types and constants of the counting semaphore bank.
// ----------------------------------------------------------------------------
package csb_pkg;

	localparam int ACTION_W  = 2;
	localparam int SEM_IDX_W = 4;
	localparam int VALUE_W   = 16;
	localparam int TASK_W    = 4;
	localparam int COUNT_W   = VALUE_W + 1;

	localparam logic signed [COUNT_W-1:0] COUNT_MAX  = 17'sd65535;
	localparam logic signed [COUNT_W-1:0] COUNT_ZERO = '0;
	localparam logic signed [COUNT_W-1:0] COUNT_ONE  = 17'sd1;

	typedef enum logic [ACTION_W-1:0] {
		ACT_INIT    = 2'd0,
		ACT_WAIT    = 2'd1,
		ACT_SIGNAL  = 2'd2,
		ACT_DESTROY = 2'd3
	} action_t;

	// controller -> datapath
	typedef struct packed {
		logic load;        // capture request, read semaphore record
		logic commit;      // apply single-result request, emit its word
		logic start_wake;  // begin releasing waiters, read first queue entry
		logic emit_wake;   // emit one released waiter, read the next if any
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic wake_path;   // request releases at least one waiter
		logic drain_more;  // more waiters follow the one being emitted
		logic out_free;    // output register can take a word this cycle
	} sts_t;

endpackage

@@ src/csb_ctrl.sv @@
// ----------------------------------------------------------------------------
// csb_ctrl
// Request sequencer: accept, execute, then release waiters one per cycle while the output register is free.
// ----------------------------------------------------------------------------
module csb_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  csb_pkg::sts_t sts,
	output csb_pkg::cmd_t cmd
);
	import csb_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_EXEC = 3'b010,
		ST_WAKE = 3'b100
	} state_t;

	state_t state_q;
	state_t state_nxt;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (sts.wake_path) begin
					cmd.start_wake = 1'b1;
					state_nxt      = ST_WAKE;
				end else if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_nxt  = ST_IDLE;
				end
			end
			ST_WAKE: begin
				if (sts.out_free) begin
					cmd.emit_wake = 1'b1;
					if (!sts.drain_more) begin
						state_nxt = ST_IDLE;
					end
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

@@ src/csb_datapath.sv @@
// ----------------------------------------------------------------------------
// csb_datapath
// Semaphore records, wait queue store, request and output registers.
// ----------------------------------------------------------------------------
module csb_datapath #(
	parameter int SEM_COUNT  = 8,
	parameter int TASK_COUNT = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  csb_pkg::cmd_t                   cmd,
	output csb_pkg::sts_t                   sts,
	input  logic [csb_pkg::ACTION_W-1:0]    action,
	input  logic [csb_pkg::SEM_IDX_W-1:0]   sem_index,
	input  logic [csb_pkg::VALUE_W-1:0]     init_value,
	input  logic [csb_pkg::TASK_W-1:0]      task_id,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            status,
	output logic                            caller_blocked,
	output logic                            wake_valid,
	output logic [csb_pkg::TASK_W-1:0]      wake_task,
	output logic                            woken_by_destroy,
	output logic                            last
);
	import csb_pkg::*;

	localparam int SW = (SEM_COUNT > 1) ? $clog2(SEM_COUNT) : 1;
	localparam int QW = $clog2(TASK_COUNT);
	localparam int FW = $clog2(TASK_COUNT + 1);
	localparam int AW = $clog2(SEM_COUNT * TASK_COUNT);
	localparam int SLOTS = SEM_COUNT * TASK_COUNT;

	typedef struct packed {
		logic signed [COUNT_W-1:0] count;
		logic [QW-1:0]             head;
		logic [QW-1:0]             tail;
		logic [FW-1:0]             fill;
	} sem_rec_t;

	function automatic logic [QW-1:0] q_next(input logic [QW-1:0] p);
		if (p == QW'(TASK_COUNT - 1)) begin
			return '0;
		end
		return p + 1'b1;
	endfunction

	function automatic logic [AW-1:0] slot(input logic [SW-1:0] s, input logic [QW-1:0] p);
		return AW'(s) * AW'(TASK_COUNT) + AW'(p);
	endfunction

	// storage
	sem_rec_t            sem_ram [SEM_COUNT];
	logic [TASK_W-1:0]   store [SLOTS];
	logic [SEM_COUNT-1:0] in_use_q;

	// request and working registers
	sem_rec_t            rec_q;
	logic [TASK_W-1:0]   store_rd_q;
	action_t             action_q;
	logic [SW-1:0]       sem_q;
	logic                sem_ok_q;
	logic [TASK_W-1:0]   task_q;
	logic [VALUE_W-1:0]  ival_q;
	logic [QW-1:0]       head_q;
	logic [FW-1:0]       fill_q;

	// output register
	logic                out_valid_q;
	logic                status_q;
	logic                blocked_q;
	logic                wake_valid_q;
	logic [TASK_W-1:0]   wake_task_q;
	logic                by_destroy_q;
	logic                last_q;

	logic                    active;
	logic                    blocks;
	logic                    full;
	logic                    req_fail;
	logic                    queue_caller;
	logic signed [COUNT_W-1:0] dec;
	logic signed [COUNT_W-1:0] inc;
	logic                    rec_we;
	sem_rec_t                rec_wd;
	logic                    st_we;
	logic                    st_re;
	logic [AW-1:0]           st_waddr;
	logic [AW-1:0]           st_raddr;

	assign active = sem_ok_q && in_use_q[sem_q];
	assign dec    = rec_q.count - COUNT_ONE;
	assign inc    = (rec_q.count < COUNT_MAX) ? rec_q.count + COUNT_ONE : rec_q.count;
	assign blocks = (rec_q.count <= COUNT_ZERO);
	assign full   = (rec_q.fill >= FW'(TASK_COUNT));

	always_comb begin
		if (!sem_ok_q) begin
			req_fail = 1'b1;
		end else if (action_q == ACT_INIT) begin
			req_fail = active;
		end else if (!active) begin
			req_fail = 1'b1;
		end else begin
			req_fail = (action_q == ACT_WAIT) && blocks && full;
		end
	end

	assign queue_caller = !req_fail && (action_q == ACT_WAIT) && blocks;

	assign sts.wake_path = !req_fail && (rec_q.fill != '0) &&
		((action_q == ACT_DESTROY) || ((action_q == ACT_SIGNAL) && (inc <= COUNT_ZERO)));
	assign sts.drain_more = (fill_q != '0);
	assign sts.out_free   = !out_valid_q || !out_stall;

	// semaphore record update
	always_comb begin
		rec_we = 1'b0;
		rec_wd = rec_q;
		if (cmd.commit && !req_fail) begin
			unique case (action_q)
				ACT_INIT: begin
					rec_we       = 1'b1;
					rec_wd.count = $signed({1'b0, ival_q});
					rec_wd.head  = '0;
					rec_wd.tail  = '0;
					rec_wd.fill  = '0;
				end
				ACT_WAIT: begin
					rec_we       = 1'b1;
					rec_wd.count = dec;
					if (blocks) begin
						rec_wd.tail = q_next(rec_q.tail);
						rec_wd.fill = rec_q.fill + 1'b1;
					end
				end
				ACT_SIGNAL: begin
					rec_we       = 1'b1;
					rec_wd.count = inc;
				end
				ACT_DESTROY: begin
					rec_we = 1'b0;
				end
				default: begin
					rec_we = 1'b0;
				end
			endcase
		end else if (cmd.start_wake && (action_q == ACT_SIGNAL)) begin
			rec_we       = 1'b1;
			rec_wd.count = inc;
			rec_wd.head  = q_next(rec_q.head);
			rec_wd.fill  = rec_q.fill - 1'b1;
		end
	end

	assign st_we    = cmd.commit && queue_caller;
	assign st_waddr = slot(sem_q, rec_q.tail);
	assign st_re    = cmd.start_wake || (cmd.emit_wake && sts.drain_more);
	assign st_raddr = slot(sem_q, cmd.start_wake ? rec_q.head : head_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rec_q <= sem_ram[SW'(sem_index)];
		end
		if (rec_we) begin
			sem_ram[sem_q] <= rec_wd;
		end
	end

	always_ff @(posedge clk) begin
		if (st_we) begin
			store[st_waddr] <= task_q;
		end
		if (st_re) begin
			store_rd_q <= store[st_raddr];
		end
	end

	// request capture and drain pointers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= action_t'(action);
			sem_q    <= SW'(sem_index);
			sem_ok_q <= (32'(sem_index) < 32'(SEM_COUNT));
			task_q   <= task_id;
			ival_q   <= init_value;
		end
		if (cmd.start_wake) begin
			head_q <= q_next(rec_q.head);
			fill_q <= (action_q == ACT_DESTROY) ? rec_q.fill - 1'b1 : '0;
		end else if (cmd.emit_wake && sts.drain_more) begin
			head_q <= q_next(head_q);
			fill_q <= fill_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q <= '0;
		end else if (cmd.commit && !req_fail && (action_q == ACT_INIT)) begin
			in_use_q[sem_q] <= 1'b1;
		end else if (cmd.commit && !req_fail && (action_q == ACT_DESTROY)) begin
			in_use_q[sem_q] <= 1'b0;
		end else if (cmd.emit_wake && !sts.drain_more && (action_q == ACT_DESTROY)) begin
			in_use_q[sem_q] <= 1'b0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit || cmd.emit_wake) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status_q     <= req_fail;
			blocked_q    <= queue_caller;
			wake_valid_q <= 1'b0;
			wake_task_q  <= '0;
			by_destroy_q <= 1'b0;
			last_q       <= 1'b1;
		end else if (cmd.emit_wake) begin
			status_q     <= 1'b0;
			blocked_q    <= 1'b0;
			wake_valid_q <= 1'b1;
			wake_task_q  <= store_rd_q;
			by_destroy_q <= (action_q == ACT_DESTROY);
			last_q       <= !sts.drain_more;
		end
	end

	assign out_valid        = out_valid_q;
	assign status           = status_q;
	assign caller_blocked   = blocked_q;
	assign wake_valid       = wake_valid_q;
	assign wake_task        = wake_task_q;
	assign woken_by_destroy = by_destroy_q;
	assign last             = last_q;

endmodule

@@ src/counting_semaphore_bank.sv @@
// Output: a request's first word is registered from the execute state, or from the wake
//   state when signal or destroy releases waiters; destroy emits one word per waiter per cycle
//   while the output register is free. A new request is taken only once the last one is
//   finished, as each reads, then writes, its semaphore record.
// Reset: arst_n clears the in-use flags and control state; records and queue slots
//   are written by init and wait before their contents are used, so no clearing pass is run.
// ----------------------------------------------------------------------------
// counting_semaphore_bank
// Bank of counting semaphores, each with a FIFO of blocked task numbers.
// ----------------------------------------------------------------------------
module counting_semaphore_bank #(
	parameter int SEM_COUNT  = 8,
	parameter int TASK_COUNT = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// request channel
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [csb_pkg::ACTION_W-1:0]    action,
	input  logic [csb_pkg::SEM_IDX_W-1:0]   sem_index,
	input  logic [csb_pkg::VALUE_W-1:0]     init_value,
	input  logic [csb_pkg::TASK_W-1:0]      task_id,
	// result channel
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            status,
	output logic                            caller_blocked,
	output logic                            wake_valid,
	output logic [csb_pkg::TASK_W-1:0]      wake_task,
	output logic                            woken_by_destroy,
	output logic                            last
);
	import csb_pkg::*;

	// The controller steps each request through three phases:
	//   idle    - take a word, read the addressed semaphore record
	//   execute - check index and in-use state, apply init/wait/signal/destroy,
	//             or start releasing waiters for a waking signal or destroy
	//   wake    - emit one released task per cycle from the wait queue
	//             store, reading the next queue entry in the same cycle
	// The datapath owns all storage: a per-semaphore record memory
	// (counter, head, tail, fill), a queue store of SEM_COUNT*TASK_COUNT
	// task numbers, the in-use flags and the output register. A finished
	// word waits in the output register; the controller holds in execute
	// or wake until that register is free.
	cmd_t cmd;
	sts_t sts;

	csb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	csb_datapath #(
		.SEM_COUNT  (SEM_COUNT),
		.TASK_COUNT (TASK_COUNT)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.action           (action),
		.sem_index        (sem_index),
		.init_value       (init_value),
		.task_id          (task_id),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.status           (status),
		.caller_blocked   (caller_blocked),
		.wake_valid       (wake_valid),
		.wake_task        (wake_task),
		.woken_by_destroy (woken_by_destroy),
		.last             (last)
	);

endmodule
